>>> hw/rtl/sps_pkg.sv
package sps_pkg;

  // Width of the fast-sample and near-hit counters (4 to 16)
  localparam int COUNTER_BITS = 8;
  localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;

  // Common width for comparing a counter with an 8-bit register
  localparam int CMP_W = (COUNTER_BITS > 8) ? COUNTER_BITS : 8;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  // Register reset values
  localparam logic [15:0] NORMAL_PERIOD_RST  = 16'd5000;
  localparam logic [15:0] FAST_PERIOD_RST    = 16'd100;
  localparam logic [15:0] DISPLAY_PERIOD_RST = 16'd20000;
  localparam logic [9:0]  PULSE_HIGH_RST     = 10'd10;
  localparam logic [7:0]  FAST_LIMIT_RST     = 8'd100;
  localparam logic [7:0]  THRESHOLD_RST      = 8'd9;
  localparam logic [15:0] NEAR_LIMIT_RST     = 16'd3528;

  // Register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_NORMAL_PERIOD  = 3'd0,
    CFG_FAST_PERIOD    = 3'd1,
    CFG_DISPLAY_PERIOD = 3'd2,
    CFG_PULSE_HIGH     = 3'd3,
    CFG_FAST_LIMIT     = 3'd4,
    CFG_THRESHOLD      = 3'd5,
    CFG_NEAR_LIMIT     = 3'd6
  } cfg_addr_t;

  // Sequencer phases, one-hot
  typedef enum logic [3:0] {
    PH_HIGH = 4'b0001,
    PH_IDLE = 4'b0010,
    PH_FAST = 4'b0100,
    PH_DISP = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [15:0] normal_period_ms;
    logic [15:0] fast_period_ms;
    logic [15:0] display_period_ms;
    logic [9:0]  pulse_high_us;
    logic [7:0]  fast_sample_cap;
    logic [7:0]  hit_threshold;
    logic [15:0] near_echo_limit_us;
  } cfg_t;

  typedef struct packed {
    logic        trigger_level;
    logic        reschedule;
    logic [15:0] delay_value;
    logic        delay_in_ms;
    logic        display_en;
    logic        speaker_en;
  } result_t;

endpackage

>>> hw/rtl/sps_cfg.sv
module sps_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [sps_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [sps_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output sps_pkg::cfg_t                       cfg
);

  // Register file, written by index
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.normal_period_ms   <= sps_pkg::NORMAL_PERIOD_RST;
      cfg.fast_period_ms     <= sps_pkg::FAST_PERIOD_RST;
      cfg.display_period_ms  <= sps_pkg::DISPLAY_PERIOD_RST;
      cfg.pulse_high_us      <= sps_pkg::PULSE_HIGH_RST;
      cfg.fast_sample_cap    <= sps_pkg::FAST_LIMIT_RST;
      cfg.hit_threshold      <= sps_pkg::THRESHOLD_RST;
      cfg.near_echo_limit_us <= sps_pkg::NEAR_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (sps_pkg::cfg_addr_t'(cfg_addr))
        sps_pkg::CFG_NORMAL_PERIOD:  cfg.normal_period_ms   <= cfg_wdata;
        sps_pkg::CFG_FAST_PERIOD:    cfg.fast_period_ms     <= cfg_wdata;
        sps_pkg::CFG_DISPLAY_PERIOD: cfg.display_period_ms  <= cfg_wdata;
        sps_pkg::CFG_PULSE_HIGH:     cfg.pulse_high_us      <= cfg_wdata[9:0];
        sps_pkg::CFG_FAST_LIMIT:     cfg.fast_sample_cap    <= cfg_wdata[7:0];
        sps_pkg::CFG_THRESHOLD:      cfg.hit_threshold      <= cfg_wdata[7:0];
        sps_pkg::CFG_NEAR_LIMIT:     cfg.near_echo_limit_us <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

>>> hw/rtl/sps_core.sv
module sps_core (
  input  logic                 clk,
  input  logic                 rst,
  input  sps_pkg::cfg_t        cfg,
  input  logic                 fire,
  input  logic                 mode,
  input  logic [15:0]          echo_us,
  output sps_pkg::result_t     result,
  output sps_pkg::phase_t      phase
);

  sps_pkg::phase_t                  phase_next;
  sps_pkg::phase_t                  prior_phase, prior_phase_next;
  logic                             fast_mode, fast_mode_next;
  logic [sps_pkg::COUNTER_BITS-1:0] fast_samples, fast_samples_next;
  logic [sps_pkg::COUNTER_BITS-1:0] near_hits, near_hits_next;
  logic                             display_on, display_on_next;
  logic                             speaker_on, speaker_on_next;
  logic                             pin_level, pin_level_next;
  logic                             resched;
  logic [15:0]                      delay;
  logic                             in_ms;
  logic                             samples_left;
  logic                             hits_over;

  assign samples_left = sps_pkg::CMP_W'(fast_samples) < sps_pkg::CMP_W'(cfg.fast_sample_cap);
  assign hits_over    = sps_pkg::CMP_W'(near_hits) > sps_pkg::CMP_W'(cfg.hit_threshold);

  // Next state and result for the request in the input register
  always_comb begin
    phase_next        = phase;
    prior_phase_next  = prior_phase;
    fast_mode_next    = fast_mode;
    fast_samples_next = fast_samples;
    near_hits_next    = near_hits;
    display_on_next   = display_on;
    speaker_on_next   = speaker_on;
    pin_level_next    = pin_level;
    resched           = 1'b0;
    delay             = '0;
    in_ms             = 1'b0;
    if (mode) begin
      // echo: arm fast sampling first, then count near hits
      if (echo_us < cfg.near_echo_limit_us) begin
        if (!fast_mode) begin
          fast_mode_next = 1'b1;
        end else if (near_hits != sps_pkg::CNT_MAX) begin
          near_hits_next = near_hits + 1'b1;
        end
      end
    end else begin
      resched = 1'b1;
      unique case (phase)
        sps_pkg::PH_HIGH: begin
          pin_level_next = 1'b1;
          if (prior_phase == sps_pkg::PH_IDLE) begin
            phase_next = fast_mode ? sps_pkg::PH_FAST : sps_pkg::PH_IDLE;
          end else if (prior_phase == sps_pkg::PH_FAST) begin
            if (samples_left) begin
              if (hits_over) begin
                phase_next      = sps_pkg::PH_DISP;
                near_hits_next  = '0;
                speaker_on_next = 1'b1;
                display_on_next = 1'b1;
              end else begin
                phase_next = sps_pkg::PH_FAST;
              end
            end else begin
              phase_next      = sps_pkg::PH_IDLE;
              fast_mode_next  = 1'b0;
              display_on_next = 1'b0;
              speaker_on_next = 1'b0;
            end
          end else if (prior_phase == sps_pkg::PH_DISP) begin
            phase_next = sps_pkg::PH_FAST;
          end
          prior_phase_next = sps_pkg::PH_HIGH;
          delay            = 16'(cfg.pulse_high_us);
          in_ms            = 1'b0;
        end
        sps_pkg::PH_IDLE: begin
          pin_level_next    = 1'b0;
          fast_samples_next = '0;
          near_hits_next    = '0;
          speaker_on_next   = 1'b0;
          display_on_next   = 1'b0;
          prior_phase_next  = sps_pkg::PH_IDLE;
          phase_next        = sps_pkg::PH_HIGH;
          delay             = cfg.normal_period_ms;
          in_ms             = 1'b1;
        end
        sps_pkg::PH_FAST: begin
          pin_level_next = 1'b0;
          if (fast_samples != sps_pkg::CNT_MAX) begin
            fast_samples_next = fast_samples + 1'b1;
          end
          prior_phase_next = sps_pkg::PH_FAST;
          phase_next       = sps_pkg::PH_HIGH;
          delay            = cfg.fast_period_ms;
          in_ms            = 1'b1;
        end
        default: begin
          // display low
          pin_level_next    = 1'b0;
          speaker_on_next   = 1'b1;
          display_on_next   = 1'b1;
          fast_samples_next = '0;
          near_hits_next    = '0;
          prior_phase_next  = sps_pkg::PH_DISP;
          phase_next        = sps_pkg::PH_HIGH;
          delay             = cfg.display_period_ms;
          in_ms             = 1'b1;
        end
      endcase
    end
  end

  // Result reflects the state after this request
  always_comb begin
    result.trigger_level = pin_level_next;
    result.reschedule    = resched;
    result.delay_value   = delay;
    result.delay_in_ms   = in_ms;
    result.display_en    = display_on_next;
    result.speaker_en    = speaker_on_next;
  end

  // State registers, updated once per request
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= sps_pkg::PH_IDLE;
      prior_phase  <= sps_pkg::PH_HIGH;
      fast_mode    <= 1'b0;
      fast_samples <= '0;
      near_hits    <= '0;
      display_on   <= 1'b0;
      speaker_on   <= 1'b0;
      pin_level    <= 1'b0;
    end else if (fire) begin
      phase        <= phase_next;
      prior_phase  <= prior_phase_next;
      fast_mode    <= fast_mode_next;
      fast_samples <= fast_samples_next;
      near_hits    <= near_hits_next;
      display_on   <= display_on_next;
      speaker_on   <= speaker_on_next;
      pin_level    <= pin_level_next;
    end
  end

endmodule

>>> hw/rtl/sonar_presence_sampler.sv
// Channel  | Dir | Signals              | Content
// ---------+-----+----------------------+-----------------------------------------
// s_*      | in  | tvalid tready tdata  | timer expiry or echo width request
//          |     | tuser                |
// m_*      | out | tvalid tready tdata  | one result per request
//          |     | tuser                |
// cfg_*    | in  | we addr wdata        | register write, no wait, no read-back
//
// One request per cycle sustained while m_tready is high; after the s_ accept a request
// passes the input register, one pass through the phase update and the result register.
// rst is synchronous and active high; it loads register defaults and the idle-low phase.
// A stalled m_ side holds the result; one more request waits in the input register
// and s_tready drops only when both are full.
module sonar_presence_sampler (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [15:0]                        s_tdata,   // [15:0] echo_us
  input  logic                               s_tuser,   // [0] mode
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [23:0]                        m_tdata,   // [0] trigger_level, [1] reschedule,
                                                        // [17:2] delay_value,
                                                        // [18] display_en, [19] speaker_en
  output logic                               m_tuser,   // [0] delay_in_ms
  input  logic                               cfg_we,
  input  logic [sps_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [sps_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  sps_pkg::cfg_t    cfg;
  sps_pkg::result_t result;
  sps_pkg::result_t out_q;
  sps_pkg::phase_t  phase;
  logic             in_valid;
  logic             in_mode;
  logic [15:0]      in_echo;
  logic             fire;

  sps_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  sps_core u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .fire    (fire),
    .mode    (in_mode),
    .echo_us (in_echo),
    .result  (result),
    .phase   (phase)
  );

  // Request moves on when the result register is free or being drained
  assign fire     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || fire;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_mode <= s_tuser;
      in_echo <= s_tdata;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_q <= result;
    end
  end

  assign m_tdata = {4'b0, out_q.speaker_en, out_q.display_en, out_q.delay_value,
                    out_q.reschedule, out_q.trigger_level};
  assign m_tuser = out_q.delay_in_ms;

  // Echo results carry no timer restart
  a_echo_no_delay: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[1] |-> (m_tdata[17:2] == 16'd0) && !m_tuser)
    else $error("echo result carries a delay");

  // Microsecond delay only comes from the trigger-high phase
  a_us_delay_pin_high: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1] && !m_tuser |-> m_tdata[0])
    else $error("microsecond delay with trigger low");

  // Millisecond delay only comes from a low phase
  a_ms_delay_pin_low: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1] && m_tuser |-> !m_tdata[0])
    else $error("millisecond delay with trigger high");

  // Display and speaker always switch together
  a_display_speaker: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[18] == m_tdata[19])
    else $error("display and speaker enables differ");

  // A timer request in a low phase always leads to trigger high
  a_low_to_high: assert property (@(posedge clk) disable iff (rst)
    fire && !in_mode && (phase != sps_pkg::PH_HIGH) |=> phase == sps_pkg::PH_HIGH)
    else $error("low phase did not move to trigger high");

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import sps_pkg::*;

  // request kinds carried in s_tuser
  localparam logic MODE_TIMER = 1'b0;
  localparam logic MODE_ECHO  = 1'b1;

  // register index with no register behind it
  localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED = 3'd7;

  // quiet cycles before a register write once all results are back
  localparam int CFG_SETTLE = 4;

  typedef enum logic [1:0] {OP_REQ, OP_CFG, OP_DRAIN} op_kind_t;

  typedef struct {
    op_kind_t              kind;
    logic                  mode;
    logic [15:0]           echo;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;
  } op_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [15:0]           s_tdata = '0;   // [15:0] echo_us
  logic                  s_tuser = 1'b0; // [0] mode
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [23:0]           m_tdata;        // [0] trigger_level, [1] reschedule,
                                         // [17:2] delay_value,
                                         // [18] display_en, [19] speaker_en
  logic                  m_tuser;        // [0] delay_in_ms
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  sonar_presence_sampler dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // pending operations and expected results
  op_t     op_q[$];
  result_t sonar_results_q[$];

  int err_cnt   = 0;
  int n_timer   = 0;
  int n_echo    = 0;
  int n_cfg     = 0;
  int n_display = 0;
  int n_results = 0;

  // sequencer shadow: phase, counters and outputs
  cfg_t                    cfg_now;
  phase_t                  ph;
  phase_t                  ph_prev;  // PH_HIGH here means no low phase recorded
  logic                    fast_on;
  logic [COUNTER_BITS-1:0] fast_cnt;
  logic [COUNTER_BITS-1:0] near_cnt;
  logic                    disp_on;
  logic                    spk_on;
  logic                    pin;

  function automatic logic [COUNTER_BITS-1:0] sat_bump(input logic [COUNTER_BITS-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  // next sequencer state and result for one request
  function automatic result_t sonar_step(input logic mode, input logic [15:0] echo);
    result_t r;
    r = '0;
    if (mode == MODE_ECHO) begin
      if (echo < cfg_now.near_echo_limit_us) begin
        if (!fast_on) fast_on = 1'b1;
        else near_cnt = sat_bump(near_cnt);
      end
    end else begin
      r.reschedule = 1'b1;
      case (ph)
        PH_HIGH: begin
          pin = 1'b1;
          if (ph_prev == PH_IDLE) begin
            ph = fast_on ? PH_FAST : PH_IDLE;
          end else if (ph_prev == PH_FAST) begin
            if (fast_cnt < cfg_now.fast_sample_cap) begin
              if (near_cnt > cfg_now.hit_threshold) begin
                ph       = PH_DISP;
                near_cnt = '0;
                spk_on   = 1'b1;
                disp_on  = 1'b1;
              end else begin
                ph = PH_FAST;
              end
            end else begin
              ph      = PH_IDLE;
              fast_on = 1'b0;
              disp_on = 1'b0;
              spk_on  = 1'b0;
            end
          end else if (ph_prev == PH_DISP) begin
            ph = PH_FAST;
          end
          // with no low phase recorded the phase stays trigger high
          ph_prev       = PH_HIGH;
          r.delay_value = {6'd0, cfg_now.pulse_high_us};
          r.delay_in_ms = 1'b0;
        end
        PH_IDLE: begin
          pin           = 1'b0;
          fast_cnt      = '0;
          near_cnt      = '0;
          spk_on        = 1'b0;
          disp_on       = 1'b0;
          ph_prev       = PH_IDLE;
          ph            = PH_HIGH;
          r.delay_value = cfg_now.normal_period_ms;
          r.delay_in_ms = 1'b1;
        end
        PH_FAST: begin
          pin           = 1'b0;
          fast_cnt      = sat_bump(fast_cnt);
          ph_prev       = PH_FAST;
          ph            = PH_HIGH;
          r.delay_value = cfg_now.fast_period_ms;
          r.delay_in_ms = 1'b1;
        end
        default: begin
          pin           = 1'b0;
          spk_on        = 1'b1;
          disp_on       = 1'b1;
          fast_cnt      = '0;
          near_cnt      = '0;
          ph_prev       = PH_DISP;
          ph            = PH_HIGH;
          r.delay_value = cfg_now.display_period_ms;
          r.delay_in_ms = 1'b1;
        end
      endcase
    end
    r.trigger_level = pin;
    r.display_en    = disp_on;
    r.speaker_en    = spk_on;
    return r;
  endfunction

  task automatic check_field(input string fld, input logic [15:0] want_v, got_v);
    if (got_v !== want_v) begin
      err_cnt++;
      if (err_cnt <= 40)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, fld, want_v, got_v);
    end
  endtask

  // monitor: register writes, accepted requests and results
  logic req_taken = 1'b0;

  always @(posedge clk) begin : watch
    result_t got;
    result_t want;
    req_taken <= s_tvalid && s_tready;
    if (rst) begin
      cfg_now.normal_period_ms   = NORMAL_PERIOD_RST;
      cfg_now.fast_period_ms     = FAST_PERIOD_RST;
      cfg_now.display_period_ms  = DISPLAY_PERIOD_RST;
      cfg_now.pulse_high_us      = PULSE_HIGH_RST;
      cfg_now.fast_sample_cap    = FAST_LIMIT_RST;
      cfg_now.hit_threshold      = THRESHOLD_RST;
      cfg_now.near_echo_limit_us = NEAR_LIMIT_RST;
      ph       = PH_IDLE;
      ph_prev  = PH_HIGH;
      fast_on  = 1'b0;
      fast_cnt = '0;
      near_cnt = '0;
      disp_on  = 1'b0;
      spk_on   = 1'b0;
      pin      = 1'b0;
    end else begin
      if (cfg_we) begin
        n_cfg++;
        case (cfg_addr)
          CFG_NORMAL_PERIOD:  cfg_now.normal_period_ms   = cfg_wdata;
          CFG_FAST_PERIOD:    cfg_now.fast_period_ms     = cfg_wdata;
          CFG_DISPLAY_PERIOD: cfg_now.display_period_ms  = cfg_wdata;
          CFG_PULSE_HIGH:     cfg_now.pulse_high_us      = cfg_wdata[9:0];
          CFG_FAST_LIMIT:     cfg_now.fast_sample_cap    = cfg_wdata[7:0];
          CFG_THRESHOLD:      cfg_now.hit_threshold      = cfg_wdata[7:0];
          CFG_NEAR_LIMIT:     cfg_now.near_echo_limit_us = cfg_wdata;
          default: ;
        endcase
      end

      // check results before queuing this edge's request
      if (m_tvalid && m_tready) begin
        got.trigger_level = m_tdata[0];
        got.reschedule    = m_tdata[1];
        got.delay_value   = m_tdata[17:2];
        got.display_en    = m_tdata[18];
        got.speaker_en    = m_tdata[19];
        got.delay_in_ms   = m_tuser;
        if (sonar_results_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 40)
            $display("%0t: result with none expected, expected nothing, got %h/%b",
                     $time, m_tdata, m_tuser);
        end else begin
          want = sonar_results_q.pop_front();
          n_results++;
          if (got.display_en) n_display++;
          check_field("trigger_level", want.trigger_level, got.trigger_level);
          check_field("reschedule", want.reschedule, got.reschedule);
          check_field("delay_value", want.delay_value, got.delay_value);
          check_field("delay_in_ms", want.delay_in_ms, got.delay_in_ms);
          check_field("display_en", want.display_en, got.display_en);
          check_field("speaker_en", want.speaker_en, got.speaker_en);
        end
      end

      if (s_tvalid && s_tready) begin
        if (s_tuser == MODE_ECHO) n_echo++;
        else n_timer++;
        sonar_results_q.push_back(sonar_step(s_tuser, s_tdata));
      end
    end
  end

  // driver: bursts of requests with random gaps, register writes when idle
  int burst_left = 0;
  int gap_left   = 0;
  int quiet_cnt  = 0;

  always @(negedge clk) begin : drive
    logic vld;
    logic we;
    vld = s_tvalid;
    we  = 1'b0;
    if (!rst) begin
      if (sonar_results_q.size() == 0 && !s_tvalid) quiet_cnt++;
      else quiet_cnt = 0;
      if (s_tvalid && !req_taken) begin
        // request still waiting for s_tready
      end else begin
        vld = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (op_q.size() > 0) begin
          case (op_q[0].kind)
            OP_REQ: begin
              vld = 1'b1;
              s_tuser <= op_q[0].mode;
              s_tdata <= op_q[0].echo;
              void'(op_q.pop_front());
              if (burst_left > 0) begin
                burst_left--;
              end else begin
                burst_left = $urandom_range(1, 24);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
              end
            end
            OP_CFG: begin
              if (quiet_cnt >= CFG_SETTLE) begin
                we = 1'b1;
                cfg_addr  <= op_q[0].addr;
                cfg_wdata <= op_q[0].data;
                void'(op_q.pop_front());
              end
            end
            default: begin
              if (sonar_results_q.size() == 0) void'(op_q.pop_front());
            end
          endcase
        end
      end
    end
    s_tvalid <= vld;
    cfg_we   <= we;
  end

  // receiver: stall pattern, redrawn with a random length when its countdown runs out
  logic [31:0] stall_pat  = '1;
  int          pat_left   = 0;
  logic        full_speed = 1'b1;

  always @(negedge clk) begin : sink
    if (pat_left == 0) begin
      stall_pat  = $urandom;
      pat_left   = $urandom_range(16, 96);
      full_speed = ($urandom_range(0, 3) == 0);
    end else begin
      pat_left--;
    end
    stall_pat = {stall_pat[30:0], stall_pat[31]};
    m_tready <= full_speed | stall_pat[0] | stall_pat[1];
  end

  task automatic add_req(input logic mode, input logic [15:0] echo);
    op_q.push_back('{kind: OP_REQ, mode: mode, echo: echo, addr: '0, data: '0});
  endtask

  task automatic add_cfg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
    op_q.push_back('{kind: OP_CFG, mode: MODE_TIMER, echo: '0, addr: addr, data: data});
  endtask

  task automatic add_drain();
    op_q.push_back('{kind: OP_DRAIN, mode: MODE_TIMER, echo: '0, addr: '0, data: '0});
  endtask

  // stimulus
  initial begin : stim
    logic [15:0] near_lim;
    logic [15:0] echo_v;

    // reset defaults: walk from idle into fast sampling
    add_req(MODE_TIMER, 16'd0);
    add_req(MODE_ECHO, NEAR_LIMIT_RST);
    add_req(MODE_ECHO, NEAR_LIMIT_RST - 16'd1);
    add_req(MODE_ECHO, 16'd0);
    add_req(MODE_TIMER, 16'hFFFF);
    add_req(MODE_TIMER, 16'd0);
    add_req(MODE_ECHO, 16'hFFFF);
    add_req(MODE_TIMER, 16'd0);

    // tight limits: fall back to idle, then reach the display phase
    add_cfg(CFG_NORMAL_PERIOD, 16'd1);
    add_cfg(CFG_FAST_PERIOD, 16'hFFFF);
    add_cfg(CFG_DISPLAY_PERIOD, 16'd2);
    add_cfg(CFG_PULSE_HIGH, 16'hFFFF);
    add_cfg(CFG_FAST_LIMIT, 16'd2);
    add_cfg(CFG_THRESHOLD, 16'd0);
    add_cfg(CFG_NEAR_LIMIT, 16'hFFFF);
    add_cfg(CFG_UNUSED, 16'h1234);
    add_req(MODE_TIMER, 16'd0);
    add_req(MODE_ECHO, 16'd0);
    add_req(MODE_TIMER, 16'd0);
    add_req(MODE_TIMER, 16'd0);
    add_req(MODE_ECHO, 16'd100);
    add_req(MODE_TIMER, 16'd0);
    add_req(MODE_TIMER, 16'd0);
    add_req(MODE_ECHO, 16'd5);
    add_req(MODE_TIMER, 16'd0);
    add_req(MODE_TIMER, 16'd0);
    add_req(MODE_TIMER, 16'd0);
    add_req(MODE_ECHO, 16'hFFFF);

    // zero near limit: no echo is near
    add_cfg(CFG_NEAR_LIMIT, 16'd0);
    add_req(MODE_ECHO, 16'd0);

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin
          add_cfg(CFG_NORMAL_PERIOD, 16'hFFFF);
          add_cfg(CFG_FAST_PERIOD, 16'hFFFF);
          add_cfg(CFG_DISPLAY_PERIOD, 16'hFFFF);
          add_cfg(CFG_PULSE_HIGH, 16'd1023);
          add_cfg(CFG_FAST_LIMIT, 16'd255);
          add_cfg(CFG_THRESHOLD, 16'd254);
          add_cfg(CFG_NEAR_LIMIT, 16'hFFFF);
          near_lim = 16'hFFFF;
        end
        1: begin
          add_cfg(CFG_NORMAL_PERIOD, 16'd1);
          add_cfg(CFG_FAST_PERIOD, 16'd1);
          add_cfg(CFG_DISPLAY_PERIOD, 16'd1);
          add_cfg(CFG_PULSE_HIGH, 16'd1);
          add_cfg(CFG_FAST_LIMIT, 16'd1);
          add_cfg(CFG_THRESHOLD, 16'd0);
          add_cfg(CFG_NEAR_LIMIT, 16'd1);
          near_lim = 16'd1;
        end
        default: begin
          near_lim = 16'($urandom_range(1000, 60000));
          add_cfg(CFG_NORMAL_PERIOD, 16'($urandom));
          add_cfg(CFG_FAST_PERIOD, 16'($urandom));
          add_cfg(CFG_DISPLAY_PERIOD, 16'($urandom));
          add_cfg(CFG_PULSE_HIGH,
                  ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(1, 1023)));
          add_cfg(CFG_FAST_LIMIT,
                  ($urandom_range(0, 5) == 0) ? 16'd0 : 16'($urandom_range(1, 30)));
          add_cfg(CFG_THRESHOLD, 16'($urandom_range(0, 6)));
          add_cfg(CFG_NEAR_LIMIT, near_lim);
        end
      endcase

      // saturate near hits so the display needs the full count
      if (p == 0) begin
        add_req(MODE_TIMER, 16'd0);
        add_req(MODE_ECHO, 16'd0);
        add_req(MODE_TIMER, 16'd0);
        add_req(MODE_TIMER, 16'd0);
        for (int k = 0; k < 262; k++) add_req(MODE_ECHO, 16'($urandom_range(0, 16'hFFFE)));
        for (int k = 0; k < 4; k++) add_req(MODE_TIMER, 16'($urandom));
      end

      for (int k = 0; k < 45; k++) begin
        if (p == 2 && k == 30) add_drain();
        if ($urandom_range(0, 1) == 0) begin
          add_req(MODE_TIMER, 16'($urandom));
        end else begin
          if ($urandom_range(0, 4) == 0) echo_v = 16'($urandom);
          else if ($urandom_range(0, 9) < 7) echo_v = 16'($urandom_range(0, near_lim - 16'd1));
          else echo_v = 16'($urandom_range(near_lim, 16'hFFFF));
          add_req(MODE_ECHO, echo_v);
        end
      end
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (op_q.size() > 0 || s_tvalid || sonar_results_q.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d timer and %0d echo requests across %0d register writes;",
             n_timer, n_echo, n_cfg);
    $display("checked %0d results, %0d of them with the display on.", n_results, n_display);
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/sps_pkg.sv
hw/rtl/sps_cfg.sv
hw/rtl/sps_core.sv
hw/rtl/sonar_presence_sampler.sv
tb/sv/tb_top.sv
